FILE: hw/rtl/cmfl_pkg.sv
`timescale 1ns / 1ps

package cmfl_pkg;

	typedef enum logic [2:0] {
		FACE_POS_X = 3'd0,
		FACE_NEG_X = 3'd1,
		FACE_NEG_Y = 3'd2,
		FACE_POS_Y = 3'd3,
		FACE_POS_Z = 3'd4,
		FACE_NEG_Z = 3'd5
	} face_t;

	// per-transaction sideband that rides along the divider
	typedef struct packed {
		face_t face;
		logic  zero;
		logic  sat_u;
		logic  sat_v;
	} side_t;

endpackage

FILE: hw/rtl/cmfl_front.sv
`timescale 1ns / 1ps

module cmfl_front #(
	parameter int DIR_WIDTH = 16
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  logic [DIR_WIDTH-1:0] dir_x,
	input  logic [DIR_WIDTH-1:0] dir_y,
	input  logic [DIR_WIDTH-1:0] dir_z,
	output logic                 valid_s2,
	output logic [DIR_WIDTH:0]   major_s2,
	output logic [DIR_WIDTH:0]   rem_u_s2,
	output logic [DIR_WIDTH:0]   rem_v_s2,
	output cmfl_pkg::side_t      side_s2
);

	localparam int MW = DIR_WIDTH + 1;

	logic [MW-1:0] xs, ys, zs;
	logic [MW-1:0] ax, ay, az;
	logic          z_major, y_major;
	logic [MW-1:0] major_c, mu_c, mv_c;
	cmfl_pkg::side_t side_c;

	logic          valid_s1;
	logic [MW-1:0] major_s1, mu_s1, mv_s1;
	cmfl_pkg::side_t side_s1;

	logic [MW:0]   sum_u, sum_v;
	logic [MW-1:0] twice_major;

	always_comb begin
		xs = {dir_x[DIR_WIDTH-1], dir_x};
		ys = {dir_y[DIR_WIDTH-1], dir_y};
		zs = {dir_z[DIR_WIDTH-1], dir_z};
		ax = xs[MW-1] ? MW'(-xs) : xs;
		ay = ys[MW-1] ? MW'(-ys) : ys;
		az = zs[MW-1] ? MW'(-zs) : zs;
		// ties resolve to z, then y
		z_major = (az >= ax) && (az >= ay);
		y_major = (ay >= ax);

		side_c.zero  = (dir_x == '0) && (dir_y == '0) && (dir_z == '0);
		side_c.sat_u = 1'b0;
		side_c.sat_v = 1'b0;
		if (z_major) begin
			side_c.face = zs[MW-1] ? cmfl_pkg::FACE_NEG_Z : cmfl_pkg::FACE_POS_Z;
			major_c     = az;
			mu_c        = zs[MW-1] ? MW'(-xs) : xs;
			mv_c        = ys;
		end else if (y_major) begin
			side_c.face = ys[MW-1] ? cmfl_pkg::FACE_NEG_Y : cmfl_pkg::FACE_POS_Y;
			major_c     = ay;
			mu_c        = xs;
			mv_c        = ys[MW-1] ? zs : MW'(-zs);
		end else begin
			side_c.face = xs[MW-1] ? cmfl_pkg::FACE_NEG_X : cmfl_pkg::FACE_POS_X;
			major_c     = ax;
			mu_c        = xs[MW-1] ? zs : MW'(-zs);
			mv_c        = ys;
		end
	end

	// minor + major lands in [0, 2*major]; the top end saturates
	always_comb begin
		sum_u       = {mu_s1[MW-1], mu_s1} + {1'b0, major_s1};
		sum_v       = {mv_s1[MW-1], mv_s1} + {1'b0, major_s1};
		twice_major = {major_s1[MW-2:0], 1'b0};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else if (en) begin
			valid_s1 <= in_valid;
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			major_s1 <= major_c;
			mu_s1    <= mu_c;
			mv_s1    <= mv_c;
			side_s1  <= side_c;

			major_s2      <= major_s1;
			rem_u_s2      <= sum_u[MW-1:0];
			rem_v_s2      <= sum_v[MW-1:0];
			side_s2.face  <= side_s1.face;
			side_s2.zero  <= side_s1.zero;
			side_s2.sat_u <= (sum_u[MW-1:0] == twice_major);
			side_s2.sat_v <= (sum_v[MW-1:0] == twice_major);
		end
	end

endmodule

FILE: hw/rtl/cmfl_div_step.sv
`timescale 1ns / 1ps

module cmfl_div_step #(
	parameter int DIR_WIDTH   = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   en,
	input  logic                   valid_in,
	input  logic [DIR_WIDTH:0]     major_in,
	input  logic [DIR_WIDTH:0]     rem_u_in,
	input  logic [DIR_WIDTH:0]     rem_v_in,
	input  logic [COORD_WIDTH-1:0] quo_u_in,
	input  logic [COORD_WIDTH-1:0] quo_v_in,
	input  cmfl_pkg::side_t        side_in,
	output logic                   valid_sn,
	output logic [DIR_WIDTH:0]     major_sn,
	output logic [DIR_WIDTH:0]     rem_u_sn,
	output logic [DIR_WIDTH:0]     rem_v_sn,
	output logic [COORD_WIDTH-1:0] quo_u_sn,
	output logic [COORD_WIDTH-1:0] quo_v_sn,
	output cmfl_pkg::side_t        side_sn
);

	localparam int MW = DIR_WIDTH + 1;

	logic          bit_u, bit_v;
	logic [MW-1:0] diff_u, diff_v;

	// one restoring step per coordinate: compare, subtract, shift
	always_comb begin
		bit_u  = (rem_u_in >= major_in);
		bit_v  = (rem_v_in >= major_in);
		diff_u = bit_u ? (rem_u_in - major_in) : rem_u_in;
		diff_v = bit_v ? (rem_v_in - major_in) : rem_v_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_sn <= 1'b0;
		end else if (en) begin
			valid_sn <= valid_in;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			major_sn <= major_in;
			rem_u_sn <= {diff_u[MW-2:0], 1'b0};
			rem_v_sn <= {diff_v[MW-2:0], 1'b0};
			quo_u_sn <= {quo_u_in[COORD_WIDTH-2:0], bit_u};
			quo_v_sn <= {quo_v_in[COORD_WIDTH-2:0], bit_v};
			side_sn  <= side_in;
		end
	end

endmodule

FILE: hw/rtl/cube_map_face_lookup_top.sv
`timescale 1ns / 1ps
// Stages from input transaction to result, in order:
// face select, offset add, one quotient bit per stage, output register.
// Throughput: one transaction per cycle unless stalled; the quotient stages stay busy.
// out_ready low with a result waiting freezes all stages together.
// Reset (arst_n, async, active low) clears only the stage valid bits.
module cube_map_face_lookup_top #(
	parameter int DIR_WIDTH   = 16,
	parameter int COORD_WIDTH = 16
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   in_valid,
	output logic                   in_ready,
	input  logic [DIR_WIDTH-1:0]   dir_x,
	input  logic [DIR_WIDTH-1:0]   dir_y,
	input  logic [DIR_WIDTH-1:0]   dir_z,
	output logic                   out_valid,
	input  logic                   out_ready,
	output logic [2:0]             face,
	output logic [COORD_WIDTH-1:0] coord_u,
	output logic [COORD_WIDTH-1:0] coord_v,
	output logic                   zero_vector
);

	localparam int MW = DIR_WIDTH + 1;
	localparam logic [COORD_WIDTH-1:0] CoordHalf = {1'b1, {(COORD_WIDTH-1){1'b0}}};
	localparam logic [COORD_WIDTH-1:0] CoordMax  = {COORD_WIDTH{1'b1}};

	logic advance;

	logic                   valid_d [COORD_WIDTH+1];
	logic [MW-1:0]          major_d [COORD_WIDTH+1];
	logic [MW-1:0]          rem_u_d [COORD_WIDTH+1];
	logic [MW-1:0]          rem_v_d [COORD_WIDTH+1];
	logic [COORD_WIDTH-1:0] quo_u_d [COORD_WIDTH+1];
	logic [COORD_WIDTH-1:0] quo_v_d [COORD_WIDTH+1];
	cmfl_pkg::side_t        side_d  [COORD_WIDTH+1];

	logic                   out_valid_q;
	logic [2:0]             face_q;
	logic [COORD_WIDTH-1:0] coord_u_q, coord_v_q;
	logic                   zero_q;

	assign advance  = !out_valid_q || out_ready;
	assign in_ready = advance;

	cmfl_front #(
		.DIR_WIDTH(DIR_WIDTH)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.en       (advance),
		.in_valid (in_valid),
		.dir_x    (dir_x),
		.dir_y    (dir_y),
		.dir_z    (dir_z),
		.valid_s2 (valid_d[0]),
		.major_s2 (major_d[0]),
		.rem_u_s2 (rem_u_d[0]),
		.rem_v_s2 (rem_v_d[0]),
		.side_s2  (side_d[0])
	);

	assign quo_u_d[0] = '0;
	assign quo_v_d[0] = '0;

	for (genvar i = 0; i < COORD_WIDTH; i++) begin : g_div
		cmfl_div_step #(
			.DIR_WIDTH  (DIR_WIDTH),
			.COORD_WIDTH(COORD_WIDTH)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.en       (advance),
			.valid_in (valid_d[i]),
			.major_in (major_d[i]),
			.rem_u_in (rem_u_d[i]),
			.rem_v_in (rem_v_d[i]),
			.quo_u_in (quo_u_d[i]),
			.quo_v_in (quo_v_d[i]),
			.side_in  (side_d[i]),
			.valid_sn (valid_d[i+1]),
			.major_sn (major_d[i+1]),
			.rem_u_sn (rem_u_d[i+1]),
			.rem_v_sn (rem_v_d[i+1]),
			.quo_u_sn (quo_u_d[i+1]),
			.quo_v_sn (quo_v_d[i+1]),
			.side_sn  (side_d[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_d[COORD_WIDTH];
		end
	end

	// zero vector wins over saturation: it reports centered coordinates on +z
	always_ff @(posedge clk) begin
		if (advance) begin
			zero_q <= side_d[COORD_WIDTH].zero;
			if (side_d[COORD_WIDTH].zero) begin
				face_q    <= cmfl_pkg::FACE_POS_Z;
				coord_u_q <= CoordHalf;
				coord_v_q <= CoordHalf;
			end else begin
				face_q    <= side_d[COORD_WIDTH].face;
				coord_u_q <= side_d[COORD_WIDTH].sat_u ? CoordMax : quo_u_d[COORD_WIDTH];
				coord_v_q <= side_d[COORD_WIDTH].sat_v ? CoordMax : quo_v_d[COORD_WIDTH];
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign face        = face_q;
	assign coord_u     = coord_u_q;
	assign coord_v     = coord_v_q;
	assign zero_vector = zero_q;

endmodule
